// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the letter class merge block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== src/dlcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcm_pkg
// field widths, codes and shared types of the letter class merge block
// ----------------------------------------------------------------------------
package dlcm_pkg;

   localparam int OP_W     = 1;
   localparam int SLOT_W   = 6;
   localparam int STATE_W  = 8;
   localparam int NEXT_W   = 8;
   localparam int TOTAL_W  = 7;
   localparam int SC_REG_W = 9;
   localparam int LC_REG_W = 7;
   localparam int APB_AW   = 3;
   localparam int APB_DW   = 32;

   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_RUN  = 1'b1;

   // register index is paddr[2]
   localparam logic REG_STATE_COUNT  = 1'b0;
   localparam logic REG_LETTER_COUNT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_NEXT_REP = 5'b00010,
      ST_REP_RD   = 5'b00100,
      ST_SCAN     = 5'b01000,
      ST_RESULT   = 5'b10000
   } fsm_state_type;

   typedef struct packed {
      logic done;
      logic match;
   } scan_status_type;

endpackage

// ===== src/dlcm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcm_req_if
// request channel: table load or classification run
// ----------------------------------------------------------------------------
interface dlcm_req_if import dlcm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [SLOT_W-1:0]   letter_slot;
   logic [STATE_W-1:0]  state_index;
   logic [NEXT_W-1:0]   target_state;

   modport source (output valid, op, letter_slot, state_index, target_state, input ready);
   modport sink   (input valid, op, letter_slot, state_index, target_state, output ready);
endinterface

// ===== src/dlcm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcm_rsp_if
// result channel: one class assignment per letter slot
// ----------------------------------------------------------------------------
interface dlcm_rsp_if import dlcm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   letter_index;
   logic [SLOT_W-1:0]   representative_slot;
   logic                is_new_class;
   logic [TOTAL_W-1:0]  class_total;
   logic                last;

   modport source (output valid, letter_index, representative_slot, is_new_class,
                   class_total, last, input ready);
   modport sink   (input valid, letter_index, representative_slot, is_new_class,
                   class_total, last, output ready);
endinterface

// ===== src/dlcm_col_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcm_col_cmp
// transition table memory and pipelined column compare engine
// ----------------------------------------------------------------------------
module dlcm_col_cmp import dlcm_pkg::*; #(
   parameter int MAX_STATES  = 256,
   parameter int MAX_LETTERS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_LETTERS)-1:0]     wr_letter,
   input  logic [$clog2(MAX_STATES)-1:0]      wr_state,
   input  logic [NEXT_W-1:0]                  wr_data,
   input  logic                               start,
   input  logic [$clog2(MAX_LETTERS)-1:0]     col_a,
   input  logic [$clog2(MAX_LETTERS)-1:0]     col_b,
   input  logic [$clog2(MAX_STATES+1)-1:0]    states,
   output scan_status_type                    status
);

   localparam int LW    = $clog2(MAX_LETTERS);
   localparam int SW    = $clog2(MAX_STATES);
   localparam int SCW   = $clog2(MAX_STATES+1);
   localparam int DEPTH = 1 << (LW + SW);

   logic [NEXT_W-1:0] table_mem [DEPTH];

   logic              busy_ff, busy_in;
   logic [SCW-1:0]    issue_ff, issue_in;
   logic              cmp_v_ff, cmp_v_in;
   logic [LW-1:0]     col_a_ff, col_b_ff;
   logic [NEXT_W-1:0] rd_a_ff, rd_b_ff;
   logic              rd_en;
   logic              mism;

   assign rd_en = busy_ff && (issue_ff != states);
   assign mism  = cmp_v_ff && (rd_a_ff != rd_b_ff);

   always_comb begin
      busy_in  = busy_ff;
      issue_in = issue_ff;
      cmp_v_in = rd_en;
      status   = '0;
      if (start) begin
         busy_in  = 1'b1;
         issue_in = '0;
         cmp_v_in = 1'b0;
      end else if (busy_ff) begin
         if (rd_en) begin
            issue_in = issue_ff + SCW'(1);
         end
         // a mismatch drops the read still in flight
         if (mism || !rd_en) begin
            status.done  = 1'b1;
            status.match = !mism;
            busy_in      = 1'b0;
            cmp_v_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cmp_v_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cmp_v_ff <= cmp_v_in;
      end
      issue_ff <= issue_in;
      if (start) begin
         col_a_ff <= col_a;
         col_b_ff <= col_b;
      end
   end

   // loads only happen while the scan engine is idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[{wr_letter, wr_state}] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= table_mem[{col_a_ff, issue_ff[SW-1:0]}];
         rd_b_ff <= table_mem[{col_b_ff, issue_ff[SW-1:0]}];
      end
   end

endmodule

// ===== src/dfa_letter_class_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_letter_class_merge
// merges dfa letter slots whose next-state columns are identical
//
//   channel  | dir | handshake          | moves
//   ---------+-----+--------------------+------------------------------------
//   req_bus  | in  | valid/ready        | table load or classification run
//   rsp_bus  | out | valid/ready        | class of one letter slot, last flag
//   apb      | in  | psel/penable/pwrite| state_count, letter_count
//
// a load request is written into the table as it is accepted, loads can stream back to back
// a run holds off requests until its last result sits in the output register
// per letter: each representative compared passes ST_NEXT_REP, ST_REP_RD and a column scan
//   on the table memory's two read ports; a letter that opens a class passes ST_NEXT_REP once more,
//   then ST_RESULT posts the result, waiting while the output register is held
// synchronous reset; no clearing pass, the table is valid once written
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfa_letter_class_merge import dlcm_pkg::*; #(
   parameter int MAX_STATES  = 256,
   parameter int MAX_LETTERS = 64
) (
   input  logic              clock,
   input  logic              reset,
   dlcm_req_if.sink          req_bus,
   dlcm_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   localparam int LW     = $clog2(MAX_LETTERS);
   localparam int SW     = $clog2(MAX_STATES);
   localparam int LCW    = $clog2(MAX_LETTERS+1);
   localparam int SCW    = $clog2(MAX_STATES+1);
   localparam int SCMP_W = (SCW > SC_REG_W) ? SCW : SC_REG_W;
   localparam int LCMP_W = (LCW > LC_REG_W) ? LCW : LC_REG_W;

   // configuration
   logic [SC_REG_W-1:0] state_count_ff;
   logic [LC_REG_W-1:0] letter_count_ff;
   logic                cfg_wr;
   logic [SCW-1:0]      states_eff;
   logic [LCW-1:0]      letters_eff;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff  <= SC_REG_W'(1);
         letter_count_ff <= LC_REG_W'(1);
      end else if (cfg_wr) begin
         case (paddr[2])
            REG_STATE_COUNT:  state_count_ff  <= pwdata[SC_REG_W-1:0];
            REG_LETTER_COUNT: letter_count_ff <= pwdata[LC_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_STATE_COUNT:  prdata = APB_DW'(state_count_ff);
         REG_LETTER_COUNT: prdata = APB_DW'(letter_count_ff);
         default:          prdata = '0;
      endcase
   end

   assign states_eff = (SCMP_W'(state_count_ff) > SCMP_W'(MAX_STATES)) ?
                       SCW'(MAX_STATES) : SCW'(state_count_ff);
   assign letters_eff = (LCMP_W'(letter_count_ff) > LCMP_W'(MAX_LETTERS)) ?
                        LCW'(MAX_LETTERS) : LCW'(letter_count_ff);

   // control
   fsm_state_type   state_ff, state_in;
   logic [LW-1:0]   letter_ff, letter_in;
   logic [LCW-1:0]  cnt_ff, cnt_in;
   logic [LCW-1:0]  j_ff, j_in;
   logic [LW-1:0]   res_rep_ff, res_rep_in;
   logic            res_new_ff, res_new_in;
   logic [LW-1:0]   rep_rd_ff;
   logic [LW-1:0]   rep_mem [MAX_LETTERS];
   logic            rep_we, rep_re;
   logic            req_acc, load_ok, scan_start, rsp_load, last_letter;
   logic            rsp_valid_ff, rsp_valid_in;
   scan_status_type scan_st;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign load_ok       = req_acc && (req_bus.op == OP_LOAD) &&
                          ({1'b0, req_bus.letter_slot} < (SLOT_W+1)'(MAX_LETTERS)) &&
                          (SCMP_W'(req_bus.state_index) < SCMP_W'(MAX_STATES));
   assign last_letter   = (LCW'(letter_ff) + LCW'(1)) == letters_eff;

   always_comb begin
      state_in    = state_ff;
      letter_in   = letter_ff;
      cnt_in      = cnt_ff;
      j_in        = j_ff;
      res_rep_in  = res_rep_ff;
      res_new_in  = res_new_ff;
      rep_we      = 1'b0;
      rep_re      = 1'b0;
      scan_start  = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_bus.op == OP_RUN)) begin
               cnt_in    = '0;
               letter_in = '0;
               j_in      = '0;
               if (letters_eff != '0) begin
                  state_in = ST_NEXT_REP;
               end
            end
         end
         ST_NEXT_REP: begin
            if (j_ff == cnt_ff) begin
               // no representative matched: letter opens a class
               rep_we     = 1'b1;
               cnt_in     = cnt_ff + LCW'(1);
               res_rep_in = letter_ff;
               res_new_in = 1'b1;
               state_in   = ST_RESULT;
            end else begin
               rep_re   = 1'b1;
               state_in = ST_REP_RD;
            end
         end
         ST_REP_RD: begin
            scan_start = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_st.done) begin
               if (scan_st.match) begin
                  res_rep_in = rep_rd_ff;
                  res_new_in = 1'b0;
                  state_in   = ST_RESULT;
               end else begin
                  j_in     = j_ff + LCW'(1);
                  state_in = ST_NEXT_REP;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               if (last_letter) begin
                  state_in = ST_IDLE;
               end else begin
                  letter_in = letter_ff + LW'(1);
                  j_in      = '0;
                  state_in  = ST_NEXT_REP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      letter_ff  <= letter_in;
      cnt_ff     <= cnt_in;
      j_ff       <= j_in;
      res_rep_ff <= res_rep_in;
      res_new_ff <= res_new_in;
   end

   // representative list: write at the class count, read below it, never the same entry
   always_ff @(posedge clock) begin
      if (rep_we) begin
         rep_mem[cnt_ff[LW-1:0]] <= letter_ff;
      end
      if (rep_re) begin
         rep_rd_ff <= rep_mem[j_ff[LW-1:0]];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bus.letter_index        <= SLOT_W'(letter_ff);
         rsp_bus.representative_slot <= SLOT_W'(res_rep_ff);
         rsp_bus.is_new_class        <= res_new_ff;
         rsp_bus.class_total         <= TOTAL_W'(cnt_ff);
         rsp_bus.last                <= last_letter;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

   dlcm_col_cmp #(
      .MAX_STATES  (MAX_STATES),
      .MAX_LETTERS (MAX_LETTERS)
   ) u_col_cmp (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (load_ok),
      .wr_letter (LW'(req_bus.letter_slot)),
      .wr_state  (SW'(req_bus.state_index)),
      .wr_data   (req_bus.target_state),
      .start     (scan_start),
      .col_a     (letter_ff),
      .col_b     (rep_rd_ff),
      .states    (states_eff),
      .status    (scan_st)
   );

   `ASSERT_IMPLIES(a_total_bound, clock, reset, rsp_bus.valid,
                   rsp_bus.class_total <= (TOTAL_W'(rsp_bus.letter_index) + TOTAL_W'(1)))
   `ASSERT_IMPLIES(a_new_self, clock, reset, rsp_bus.valid && rsp_bus.is_new_class,
                   rsp_bus.representative_slot == rsp_bus.letter_index)
   `ASSERT_IMPLIES(a_merge_older, clock, reset, rsp_bus.valid && !rsp_bus.is_new_class,
                   rsp_bus.representative_slot < rsp_bus.letter_index)
   `ASSERT_NEVER(a_scan_idle, clock, reset, scan_st.done && (state_ff != ST_SCAN))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// letter class merge: table loads and classification runs are checked
// against a behavioral copy of the table and the class search. Runs use
// small structured tables with near-identical columns, plus zero and
// saturated register settings, under random request gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench;
   import dlcm_pkg::*;

   localparam int TB_MAX_STATES  = 256;
   localparam int TB_MAX_LETTERS = 64;
   localparam int TOTAL_ITEMS    = 370;
   localparam int IDLE_SETTLE    = 16;
   localparam int TIMEOUT_NS     = 4_000_000;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SLOT_W-1:0]  letter_slot;
      logic [STATE_W-1:0] state_index;
      logic [NEXT_W-1:0]  target_state;
   } dfa_request_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  letter_index;
      logic [SLOT_W-1:0]  representative_slot;
      logic               is_new_class;
      logic [TOTAL_W-1:0] class_total;
      logic               last;
   } letter_class_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [APB_AW-1:0] paddr   = '0;
   logic [APB_DW-1:0] pwdata  = '0;
   logic [APB_DW-1:0] prdata;
   logic              pready;

   // request driver and result stall state
   logic               send_valid = 1'b0;
   logic [OP_W-1:0]    send_op    = OP_LOAD;
   logic [SLOT_W-1:0]  send_slot  = '0;
   logic [STATE_W-1:0] send_state = '0;
   logic [NEXT_W-1:0]  send_next  = '0;
   logic               take_ready = 1'b0;
   logic               req_fired  = 1'b0;
   int unsigned        burst_left = 0;
   int unsigned        gap_left   = 0;
   logic [15:0]        ready_pattern = 16'hFFFF;
   int unsigned        pattern_left  = 0;
   dfa_request_type    next_request;

   dfa_request_type  dfa_requests[$];
   letter_class_type pending_classes[$];

   // behavioral copy of the block
   logic [NEXT_W-1:0]   table_copy [TB_MAX_LETTERS][TB_MAX_STATES];
   logic [SLOT_W-1:0]   rep_slots [TB_MAX_LETTERS];
   int unsigned         class_count = 0;
   logic [SC_REG_W-1:0] sc_reg = 1;
   logic [LC_REG_W-1:0] lc_reg = 1;

   // stimulus side view of the registers
   int unsigned cur_sc = 1;
   int unsigned cur_lc = 1;

   int unsigned error_count  = 0;
   int unsigned queued_items = 0;
   int unsigned loads_seen   = 0;
   int unsigned runs_seen    = 0;
   int unsigned results_seen = 0;
   int unsigned sc_lo = 511, sc_hi = 0, lc_lo = 127, lc_hi = 0;

   dlcm_req_if req_bus();
   dlcm_rsp_if rsp_bus();

   assign req_bus.valid        = send_valid;
   assign req_bus.op           = send_op;
   assign req_bus.letter_slot  = send_slot;
   assign req_bus.state_index  = send_state;
   assign req_bus.target_state = send_next;
   assign rsp_bus.ready        = take_ready;

   dfa_letter_class_merge #(
      .MAX_STATES (TB_MAX_STATES),
      .MAX_LETTERS(TB_MAX_LETTERS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // class search over the copied table, one expected result per letter
   // ------------------------------------------------------------------
   function automatic void classify_letters();
      int unsigned      states;
      int unsigned      letters;
      int unsigned      rep;
      bit               fresh;
      bit               same;
      letter_class_type res;
      states  = (sc_reg > TB_MAX_STATES) ? TB_MAX_STATES : sc_reg;
      letters = (lc_reg > TB_MAX_LETTERS) ? TB_MAX_LETTERS : lc_reg;
      class_count = 0;
      for (int i = 0; i < letters; i++) begin
         rep   = i;
         fresh = 1'b1;
         // oldest representative first, first full column match wins
         for (int j = 0; j < class_count && fresh; j++) begin
            same = 1'b1;
            for (int s = 0; s < states; s++) begin
               if (table_copy[i][s] != table_copy[rep_slots[j]][s]) same = 1'b0;
            end
            if (same) begin
               rep   = rep_slots[j];
               fresh = 1'b0;
            end
         end
         if (fresh) begin
            rep_slots[class_count] = SLOT_W'(i);
            class_count++;
         end
         res.letter_index        = SLOT_W'(i);
         res.representative_slot = SLOT_W'(rep);
         res.is_new_class        = fresh;
         res.class_total         = TOTAL_W'(class_count);
         res.last                = (i + 1 == letters);
         pending_classes.push_back(res);
      end
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_class();
      letter_class_type want;
      if (pending_classes.size() == 0) begin
         $display("%0t: result for letter %0d with no run outstanding",
                  $time, rsp_bus.letter_index);
         error_count++;
      end else begin
         want = pending_classes.pop_front();
         results_seen++;
         compare_field("letter_index", want.letter_index, rsp_bus.letter_index);
         compare_field("representative_slot", want.representative_slot,
                       rsp_bus.representative_slot);
         compare_field("is_new_class", want.is_new_class, rsp_bus.is_new_class);
         compare_field("class_total", want.class_total, rsp_bus.class_total);
         compare_field("last", want.last, rsp_bus.last);
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: registers, accepted requests, accepted results
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
         sc_reg = 1;
         lc_reg = 1;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_STATE_COUNT) begin
                  sc_reg = pwdata[SC_REG_W-1:0];
                  if (sc_reg < sc_lo) sc_lo = sc_reg;
                  if (sc_reg > sc_hi) sc_hi = sc_reg;
               end else begin
                  lc_reg = pwdata[LC_REG_W-1:0];
                  if (lc_reg < lc_lo) lc_lo = lc_reg;
                  if (lc_reg > lc_hi) lc_hi = lc_reg;
               end
            end else if (paddr[2] == REG_STATE_COUNT) begin
               compare_field("state_count readback", sc_reg, prdata);
            end else begin
               compare_field("letter_count readback", lc_reg, prdata);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.op == OP_LOAD) begin
               table_copy[req_bus.letter_slot][req_bus.state_index] = req_bus.target_state;
               loads_seen++;
            end else begin
               classify_letters();
               runs_seen++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) check_class();
      end
   end

   // ------------------------------------------------------------------
   // request driver: bursts of random length, random gaps between them
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!send_valid || req_fired)) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            send_valid <= 1'b0;
         end else if (dfa_requests.size() != 0) begin
            next_request = dfa_requests.pop_front();
            send_valid <= 1'b1;
            send_op    <= next_request.op;
            send_slot  <= next_request.letter_slot;
            send_state <= next_request.state_index;
            send_next  <= next_request.target_state;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   // result stalls follow a rotating pattern that is swapped now and then
   always @(negedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0:       ready_pattern <= 16'hFFFF;
               1:       ready_pattern <= 16'h8001;
               default: ready_pattern <= 16'($urandom) | 16'h0001;
            endcase
            pattern_left <= $urandom_range(50, 300);
         end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            pattern_left  <= pattern_left - 1;
         end
         take_ready <= ready_pattern[0];
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_load(input int unsigned slot, input int unsigned state,
                             input int unsigned next);
      dfa_request_type item;
      item.op           = OP_LOAD;
      item.letter_slot  = SLOT_W'(slot);
      item.state_index  = STATE_W'(state);
      item.target_state = NEXT_W'(next);
      dfa_requests.push_back(item);
      queued_items++;
   endtask

   task automatic queue_run();
      dfa_request_type item;
      item.op           = OP_RUN;
      item.letter_slot  = SLOT_W'($urandom);
      item.state_index  = STATE_W'($urandom);
      item.target_state = NEXT_W'($urandom);
      dfa_requests.push_back(item);
      queued_items++;
   endtask

   task automatic queue_noise(input int unsigned count);
      repeat (count) queue_load($urandom_range(0, 63), $urandom_range(0, 255),
                                $urandom_range(0, 255));
   endtask

   task automatic apb_access(input logic do_write, input logic reg_idx,
                             input logic [APB_DW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= do_write;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_counts(input int unsigned sc, input int unsigned lc);
      if ($urandom_range(0, 1)) begin
         apb_access(1'b1, REG_STATE_COUNT, sc);
         apb_access(1'b1, REG_LETTER_COUNT, lc);
      end else begin
         apb_access(1'b1, REG_LETTER_COUNT, lc);
         apb_access(1'b1, REG_STATE_COUNT, sc);
      end
      if ($urandom_range(0, 2) == 0) begin
         apb_access(1'b0, REG_STATE_COUNT, '0);
         apb_access(1'b0, REG_LETTER_COUNT, '0);
      end
      cur_sc = sc;
      cur_lc = lc;
   endtask

   // block idle: nothing queued, nothing in flight, all results back
   task automatic wait_idle();
      bit busy;
      busy = 1'b1;
      // recheck after settling, a request popped on the same edge shows up late
      while (busy) begin
         while (dfa_requests.size() != 0 || send_valid || pending_classes.size() != 0)
            @(negedge clock);
         repeat (IDLE_SETTLE) @(negedge clock);
         busy = (dfa_requests.size() != 0) || send_valid ||
                (pending_classes.size() != 0);
      end
   endtask

   // writes every entry a run can read, columns drawn from up to max_classes prototypes
   task automatic build_table(input int unsigned max_classes);
      int unsigned       eff_s, eff_l, fill_s, fill_l, n_protos, pick;
      logic [NEXT_W-1:0] protos [TB_MAX_LETTERS][TB_MAX_STATES];
      int unsigned       proto_of [TB_MAX_LETTERS];
      bit                by_state;
      eff_s = (cur_sc > TB_MAX_STATES) ? TB_MAX_STATES : cur_sc;
      eff_l = (cur_lc > TB_MAX_LETTERS) ? TB_MAX_LETTERS : cur_lc;
      // one state past the compared range in case the scan reads ahead
      fill_s = (eff_s < TB_MAX_STATES) ? eff_s + 1 : TB_MAX_STATES;
      fill_l = (eff_l == 0) ? 1 : eff_l;
      n_protos = $urandom_range(1, (max_classes < fill_l) ? max_classes : fill_l);
      for (int s = 0; s < fill_s; s++) protos[0][s] = NEXT_W'($urandom);
      for (int p = 1; p < n_protos; p++) begin
         for (int s = 0; s < fill_s; s++) protos[p][s] = protos[0][s];
         // near copies that differ late keep the column scans long
         if (eff_s != 0) begin
            pick = $urandom_range(0, 1) ? eff_s - 1 : $urandom_range(0, eff_s - 1);
            protos[p][pick] = NEXT_W'($urandom);
         end
      end
      for (int i = 0; i < fill_l; i++) proto_of[i] = $urandom_range(0, n_protos - 1);
      by_state = $urandom_range(0, 1);
      if (by_state) begin
         for (int s = 0; s < fill_s; s++)
            for (int i = 0; i < fill_l; i++) queue_load(i, s, protos[proto_of[i]][s]);
      end else begin
         for (int i = 0; i < fill_l; i++)
            for (int s = 0; s < fill_s; s++) queue_load(i, s, protos[proto_of[i]][s]);
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned sc, lc, eff_s, eff_l;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: one state, one letter
      apb_access(1'b0, REG_STATE_COUNT, '0);
      apb_access(1'b0, REG_LETTER_COUNT, '0);
      queue_load(0, 0, 8'h00);
      queue_load(0, 1, 8'hFF);
      queue_run();

      // merge, new class on last-state difference, new class on first
      wait_idle();
      set_counts(2, 4);
      queue_load(0, 0, 8'h00);
      queue_load(0, 1, 8'hFF);
      queue_load(1, 0, 8'h00);
      queue_load(1, 1, 8'hFF);
      queue_load(2, 0, 8'h00);
      queue_load(2, 1, 8'hFE);
      queue_load(3, 0, 8'hFF);
      queue_load(3, 1, 8'h00);
      for (int i = 0; i < 4; i++) queue_load(i, 2, $urandom_range(0, 255));
      queue_load(63, 255, 8'hFF);
      queue_load(63, 0, 8'h00);
      queue_run();

      // no letters: no results
      wait_idle();
      set_counts(2, 0);
      queue_run();

      // no states: every letter merges into slot 0
      wait_idle();
      set_counts(0, 3);
      queue_run();

      // full state range, then state count above it
      wait_idle();
      set_counts(256, 1);
      queue_run();
      wait_idle();
      set_counts(511, 1);
      queue_run();

      // full letter range, then letter count above it
      wait_idle();
      set_counts(1, 64);
      build_table(TB_MAX_LETTERS);
      queue_run();
      wait_idle();
      set_counts(1, 127);
      queue_run();

      while (queued_items < TOTAL_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0: begin
               lc = $urandom_range(20, 64);
               sc = $urandom_range(1, 3);
            end
            1: begin
               lc = $urandom_range(65, 127);
               sc = $urandom_range(0, 2);
            end
            2: begin
               lc = $urandom_range(1, 4);
               sc = $urandom_range(9, 40);
            end
            3: begin
               lc = $urandom_range(0, 3);
               sc = $urandom_range(0, 2);
            end
            4: begin
               lc = $urandom_range(1, 2);
               sc = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
                                                : $urandom_range(41, 120);
            end
            default: begin
               lc = $urandom_range(1, 10);
               sc = $urandom_range(1, 8);
            end
         endcase
         set_counts(sc, lc);
         if ($urandom_range(0, 1)) queue_noise($urandom_range(1, 3));
         build_table(($urandom_range(0, 3) == 0) ? TB_MAX_LETTERS : 6);
         // a stray write after the load can break the class structure
         if ($urandom_range(0, 4) == 0) queue_noise(1);
         queue_run();
         if ($urandom_range(0, 3) == 0) begin
            // rerun on the same table with counts no larger than before
            wait_idle();
            eff_s = (cur_sc > TB_MAX_STATES) ? TB_MAX_STATES : cur_sc;
            eff_l = (cur_lc > TB_MAX_LETTERS) ? TB_MAX_LETTERS : cur_lc;
            set_counts($urandom_range(0, eff_s), $urandom_range(0, eff_l));
            queue_run();
         end
      end

      wait_idle();
      $display("covered %0d runs with %0d letter results and %0d table loads",
               runs_seen, results_seen, loads_seen);
      $display("state_count ranged %0d..%0d, letter_count %0d..%0d",
               sc_lo, sc_hi, lc_lo, lc_hi);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", pending_classes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== dfa_letter_class_merge.f =====
+incdir+src
src/dlcm_pkg.sv
src/dlcm_req_if.sv
src/dlcm_rsp_if.sv
src/dlcm_col_cmp.sv
src/dfa_letter_class_merge.sv
tb/testbench.sv
